@@ rtl/core/rawf_pkg.sv @@
package rawf_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_AW   = $clog2(NUM_REGS);
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 32;
  localparam int SH_W     = 5;
  localparam int FLAG_W   = 4;
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [3:0] OPC_ADD = 4'd0;
  localparam logic [3:0] OPC_AND = 4'd1;
  localparam logic [3:0] OPC_ASR = 4'd2;
  localparam logic [3:0] OPC_LSR = 4'd3;
  localparam logic [3:0] OPC_LSL = 4'd4;
  localparam logic [3:0] OPC_NOT = 4'd5;
  localparam logic [3:0] OPC_ORR = 4'd6;
  localparam logic [3:0] OPC_SUB = 4'd7;
  localparam logic [3:0] OPC_XOR = 4'd8;
  localparam logic [3:0] OPC_MOV = 4'd9;
  localparam logic [3:0] OPC_CMP = 4'd10;
  localparam logic [3:0] OPC_TST = 4'd11;

  typedef enum logic [3:0] {
    FN_NOP,
    FN_ADD,
    FN_SUB,
    FN_AND,
    FN_ORR,
    FN_XOR,
    FN_NOT,
    FN_ASR,
    FN_LSR,
    FN_LSL,
    FN_MOV
  } fn_t;

  typedef struct packed {
    fn_t               fn;
    logic [IDX_W-1:0]  rsel0;
    logic [IDX_W-1:0]  rsel1;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              upd;
    logic [SH_W-1:0]   shamt;
    logic [DATA_W-1:0] imm;
  } uop_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    idx_ok = ({3'b000, idx} < 6'(NUM_REGS));
  endfunction

endpackage

@@ rtl/core/rawf_front.sv @@
module rawf_front
  import rawf_pkg::*;
(
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_opcode,
  input  logic                in_set_flags,
  input  logic [IDX_W-1:0]    in_dest_reg,
  input  logic [IDX_W-1:0]    in_src_a_reg,
  input  logic [IDX_W-1:0]    in_src_b_reg,
  input  logic [SH_W-1:0]     in_shift_amount,
  input  logic [DATA_W-1:0]   in_immediate,
  output logic                q_push,
  output uop_t                q_uop,
  input  logic                q_full
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_uop        = '0;
    q_uop.fn     = FN_NOP;
    q_uop.rsel0  = in_src_a_reg;
    q_uop.rsel1  = in_src_b_reg;
    q_uop.wr_idx = in_dest_reg;
    q_uop.shamt  = in_shift_amount;
    q_uop.imm    = in_immediate;
    q_uop.wr_en  = 1'b1;
    q_uop.upd    = in_set_flags;
    case (in_opcode)
      OPC_ADD: q_uop.fn = FN_ADD;
      OPC_AND: q_uop.fn = FN_AND;
      OPC_ASR: q_uop.fn = FN_ASR;
      OPC_LSR: q_uop.fn = FN_LSR;
      OPC_LSL: q_uop.fn = FN_LSL;
      OPC_NOT: q_uop.fn = FN_NOT;
      OPC_ORR: q_uop.fn = FN_ORR;
      OPC_SUB: q_uop.fn = FN_SUB;
      OPC_XOR: q_uop.fn = FN_XOR;
      OPC_MOV: begin
        q_uop.fn  = FN_MOV;
        q_uop.upd = 1'b1;
      end
      OPC_CMP: begin
        q_uop.fn    = FN_SUB;
        q_uop.rsel0 = in_dest_reg;
        q_uop.rsel1 = in_src_a_reg;
        q_uop.wr_en = 1'b0;
        q_uop.upd   = 1'b1;
      end
      OPC_TST: begin
        q_uop.fn    = FN_AND;
        q_uop.rsel0 = in_dest_reg;
        q_uop.rsel1 = in_src_a_reg;
        q_uop.wr_en = 1'b0;
        q_uop.upd   = 1'b1;
      end
      default: begin
        q_uop.fn    = FN_NOP;
        q_uop.wr_en = 1'b0;
        q_uop.upd   = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/rawf_queue.sv @@
module rawf_queue
  import rawf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  uop_t push_uop,
  output logic full,
  input  logic pop,
  output logic valid,
  output uop_t pop_uop
);

  uop_t           ent_r [QDEPTH];
  logic [QAW-1:0] wptr_r;
  logic [QAW-1:0] rptr_r;
  logic [QAW:0]   cnt_r;
  logic [QAW:0]   cnt_nxt;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_uop = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_uop;
    end
  end

endmodule

@@ rtl/core/rawf_back.sv @@
module rawf_back
  import rawf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  uop_t              q_uop,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_result_value,
  output logic [FLAG_W-1:0] out_flags_out
);

  logic [DATA_W-1:0] rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;

  uop_t              ex_uop_r;
  logic              ex_valid_r;
  logic              ex_valid_nxt;
  logic [DATA_W-1:0] rd0_data_r;
  logic [DATA_W-1:0] rd1_data_r;
  logic              rd0_ok_r;
  logic              rd1_ok_r;
  logic [FLAG_W-1:0] flags_r;
  logic [FLAG_W-1:0] flags_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_result_r;
  logic [FLAG_W-1:0] out_flags_r;

  logic              adv;
  logic              wen;
  logic [DATA_W-1:0] opx;
  logic [DATA_W-1:0] opy;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] res;
  logic              c_bit;
  logic              v_bit;
  logic              byp0;
  logic              byp1;

  assign adv   = ex_valid_r && (!out_valid_r || !out_stall);
  assign q_pop = q_valid && (!ex_valid_r || adv);
  assign wen   = adv && ex_uop_r.wr_en && idx_ok(ex_uop_r.wr_idx);
  assign byp0  = wen && (ex_uop_r.wr_idx == q_uop.rsel0);
  assign byp1  = wen && (ex_uop_r.wr_idx == q_uop.rsel1);

  assign opx  = rd0_ok_r ? rd0_data_r : '0;
  assign opy  = rd1_ok_r ? rd1_data_r : '0;
  assign sum  = {1'b0, opx} + {1'b0, opy};
  assign diff = {1'b0, opx} - {1'b0, opy};

  always_comb begin
    res   = '0;
    c_bit = 1'b0;
    v_bit = 1'b0;
    case (ex_uop_r.fn)
      FN_ADD: begin
        res   = sum[DATA_W-1:0];
        c_bit = sum[DATA_W];
        v_bit = ~(opx[DATA_W-1] ^ opy[DATA_W-1]) & (opx[DATA_W-1] ^ res[DATA_W-1]);
      end
      FN_SUB: begin
        res   = diff[DATA_W-1:0];
        c_bit = ~diff[DATA_W];
        v_bit = (opx[DATA_W-1] ^ opy[DATA_W-1]) & (opx[DATA_W-1] ^ res[DATA_W-1]);
      end
      FN_AND:  res = opx & opy;
      FN_ORR:  res = opx | opy;
      FN_XOR:  res = opx ^ opy;
      FN_NOT:  res = ~opx;
      FN_ASR:  res = DATA_W'($signed(opx) >>> ex_uop_r.shamt);
      FN_LSR:  res = opx >> ex_uop_r.shamt;
      FN_LSL:  res = opx << ex_uop_r.shamt;
      FN_MOV:  res = ex_uop_r.imm;
      default: res = '0;
    endcase
  end

  always_comb begin
    flags_nxt = flags_r;
    if (ex_uop_r.upd) begin
      flags_nxt = {res[DATA_W-1], (res == '0), c_bit, v_bit};
    end
  end

  always_comb begin
    ex_valid_nxt = ex_valid_r;
    if (q_pop) begin
      ex_valid_nxt = 1'b1;
    end else if (adv) begin
      ex_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      rf_vld_r    <= '0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        flags_r <= flags_nxt;
      end
      if (wen) begin
        rf_vld_r[REG_AW'(ex_uop_r.wr_idx)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      rf_mem[REG_AW'(ex_uop_r.wr_idx)] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_uop_r   <= q_uop;
      rd0_data_r <= byp0 ? res : rf_mem[REG_AW'(q_uop.rsel0)];
      rd1_data_r <= byp1 ? res : rf_mem[REG_AW'(q_uop.rsel1)];
      rd0_ok_r   <= idx_ok(q_uop.rsel0) && (byp0 || rf_vld_r[REG_AW'(q_uop.rsel0)]);
      rd1_ok_r   <= idx_ok(q_uop.rsel1) && (byp1 || rf_vld_r[REG_AW'(q_uop.rsel1)]);
    end
    if (adv) begin
      out_result_r <= res;
      out_flags_r  <= flags_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_flags_out    = out_flags_r;

endmodule

@@ rtl/core/register_alu_with_flags.sv @@
// Executes one ARM-style data-processing request per cycle with the output free, on an
// 8-entry, 32-bit register file and keeps the NZCV flags; every request yields exactly one
// result. Requests are decoded on entry and parked in a two-entry queue; the execute side
// reads two register operands at the pop into registers, then computes and writes back,
// forwarding a result straight to a dependent request behind it. Sustained rate is one
// request per cycle with the output free, set by the execute step and its two-read
// register file; a request passes the queue, then the execute and output registers.
module register_alu_with_flags
  import rawf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_opcode,
  input  logic              in_set_flags,
  input  logic [IDX_W-1:0]  in_dest_reg,
  input  logic [IDX_W-1:0]  in_src_a_reg,
  input  logic [IDX_W-1:0]  in_src_b_reg,
  input  logic [SH_W-1:0]   in_shift_amount,
  input  logic [DATA_W-1:0] in_immediate,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_result_value,
  output logic [FLAG_W-1:0] out_flags_out
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  uop_t push_uop;
  uop_t pop_uop;

  rawf_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_set_flags    (in_set_flags),
    .in_dest_reg     (in_dest_reg),
    .in_src_a_reg    (in_src_a_reg),
    .in_src_b_reg    (in_src_b_reg),
    .in_shift_amount (in_shift_amount),
    .in_immediate    (in_immediate),
    .q_push          (q_push),
    .q_uop           (push_uop),
    .q_full          (q_full)
  );

  rawf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_uop (push_uop),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_uop  (pop_uop)
  );

  rawf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_uop            (pop_uop),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_flags_out    (out_flags_out)
  );

endmodule

@@ rtl/core/rawf_checker.sv @@
module rawf_checker
  import rawf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_result_value,
  input logic [FLAG_W-1:0] out_flags_out
);

  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in_open: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_flags_out))
    else $error("stalled result changed or dropped");

  a_nz_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_flags_out[3] && out_flags_out[2]))
    else $error("N and Z both set");

endmodule

bind register_alu_with_flags rawf_checker u_rawf_checker (.*);

@@ dv/tb_register_alu_with_flags.sv @@
`timescale 1ns / 100ps

module tb_register_alu_with_flags;
  import rawf_pkg::*;

  localparam logic [3:0] OPC_UNUSED_BASE = 4'd12;
  localparam int FLG_N = 3;
  localparam int FLG_Z = 2;
  localparam int FLG_C = 1;
  localparam int FLG_V = 0;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [3:0]        opcode;
    logic              set_flags;
    logic [IDX_W-1:0]  dest;
    logic [IDX_W-1:0]  src_a;
    logic [IDX_W-1:0]  src_b;
    logic [SH_W-1:0]   shamt;
    logic [DATA_W-1:0] imm;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [FLAG_W-1:0] flags;
  } alu_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [3:0]        in_opcode = '0;
  logic              in_set_flags = 1'b0;
  logic [IDX_W-1:0]  in_dest_reg = '0;
  logic [IDX_W-1:0]  in_src_a_reg = '0;
  logic [IDX_W-1:0]  in_src_b_reg = '0;
  logic [SH_W-1:0]   in_shift_amount = '0;
  logic [DATA_W-1:0] in_immediate = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_result_value;
  logic [FLAG_W-1:0] out_flags_out;

  logic [DATA_W-1:0] arch_regs [NUM_REGS];
  logic [FLAG_W-1:0] arch_flags;
  alu_res_t          pending_results [$];

  int  send_idle_pct = 0;
  int  out_stall_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int  hold_left = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_errors = 0;

  register_alu_with_flags u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_set_flags     (in_set_flags),
    .in_dest_reg      (in_dest_reg),
    .in_src_a_reg     (in_src_a_reg),
    .in_src_b_reg     (in_src_b_reg),
    .in_shift_amount  (in_shift_amount),
    .in_immediate     (in_immediate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_flags_out    (out_flags_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_register_alu_with_flags NOT OK");
    $finish;
  end

  function automatic logic [FLAG_W-1:0] nz_flags(input logic [DATA_W-1:0] v);
    logic [FLAG_W-1:0] f;
    f = '0;
    f[FLG_N] = v[DATA_W-1];
    f[FLG_Z] = (v == '0);
    return f;
  endfunction

  function automatic alu_req_t mk_req(input logic [3:0] op, input logic s,
                                      input int rd, input int ra, input int rb,
                                      input int sh, input logic [DATA_W-1:0] imm);
    alu_req_t r;
    r.opcode    = op;
    r.set_flags = s;
    r.dest      = IDX_W'(rd);
    r.src_a     = IDX_W'(ra);
    r.src_b     = IDX_W'(rb);
    r.shamt     = SH_W'(sh);
    r.imm       = imm;
    return r;
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t r;
    r.opcode = 4'($urandom_range(11));
    if ($urandom_range(99) < 15)
      r.opcode = OPC_MOV;
    else if ($urandom_range(99) < 3)
      r.opcode = OPC_UNUSED_BASE + 4'($urandom_range(3));
    r.set_flags = 1'($urandom_range(1));
    r.dest      = IDX_W'($urandom_range(NUM_REGS - 1));
    r.src_a     = IDX_W'($urandom_range(NUM_REGS - 1));
    r.src_b     = IDX_W'($urandom_range(NUM_REGS - 1));
    r.shamt     = SH_W'($urandom_range(31));
    case ($urandom_range(7))
      0: r.imm = '0;
      1: r.imm = '1;
      2: r.imm = 32'h8000_0000;
      3: r.imm = 32'h7fff_ffff;
      4: r.imm = DATA_W'($urandom_range(15));
      default: r.imm = $urandom();
    endcase
    return r;
  endfunction

  task automatic execute_req(input alu_req_t r);
    logic [DATA_W-1:0] a, b, d, x, y, res;
    logic [DATA_W:0]   sum;
    logic [FLAG_W-1:0] nf;
    logic              wr, upd;
    a   = arch_regs[r.src_a];
    b   = arch_regs[r.src_b];
    d   = arch_regs[r.dest];
    res = '0;
    nf  = arch_flags;
    wr  = 1'b0;
    upd = r.set_flags;
    case (r.opcode)
      OPC_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        res = sum[DATA_W-1:0];
        nf = nz_flags(res);
        nf[FLG_C] = sum[DATA_W];
        nf[FLG_V] = (a[DATA_W-1] == b[DATA_W-1]) && (res[DATA_W-1] != a[DATA_W-1]);
        wr = 1'b1;
      end
      OPC_SUB, OPC_CMP: begin
        x = (r.opcode == OPC_SUB) ? a : d;
        y = (r.opcode == OPC_SUB) ? b : a;
        res = x - y;
        nf = nz_flags(res);
        nf[FLG_C] = (x >= y);
        nf[FLG_V] = (x[DATA_W-1] != y[DATA_W-1]) && (res[DATA_W-1] != x[DATA_W-1]);
        wr = (r.opcode == OPC_SUB);
        if (r.opcode == OPC_CMP)
          upd = 1'b1;
      end
      OPC_AND: begin
        res = a & b;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_ORR: begin
        res = a | b;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_XOR: begin
        res = a ^ b;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_ASR: begin
        res = $signed(a) >>> r.shamt;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_LSR: begin
        res = a >> r.shamt;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_LSL: begin
        res = a << r.shamt;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_NOT: begin
        res = ~a;
        nf = nz_flags(res);
        wr = 1'b1;
      end
      OPC_MOV: begin
        res = r.imm;
        nf = nz_flags(res);
        wr = 1'b1;
        upd = 1'b1;
      end
      OPC_TST: begin
        res = d & a;
        nf = nz_flags(res);
        upd = 1'b1;
      end
      default: begin
        upd = 1'b0;
      end
    endcase
    if (wr)
      arch_regs[r.dest] = res;
    if (upd)
      arch_flags = nf;
    pending_results.push_back(alu_res_t'{value: res, flags: arch_flags});
  endtask

  task automatic issue_req(input alu_req_t r);
    in_valid        <= 1'b1;
    in_opcode       <= r.opcode;
    in_set_flags    <= r.set_flags;
    in_dest_reg     <= r.dest;
    in_src_a_reg    <= r.src_a;
    in_src_b_reg    <= r.src_b;
    in_shift_amount <= r.shamt;
    in_immediate    <= r.imm;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    execute_req(r);
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct)
        @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Results: check each accepted result in order.
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %h flags_out %h",
               out_result_value, out_flags_out);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_result_value);
          n_errors++;
        end
        if (out_flags_out !== want.flags) begin
          $error("flags_out: expected %h, got %h", want.flags, out_flags_out);
          n_errors++;
        end
      end
    end
  end

  // Receiver: hold off for a counted stretch on request, else stall at random.
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    out_stall_pct = 0;
    issue_req(mk_req(OPC_MOV, 1'b0, 0, 0, 0, 0, 32'h0000_0000));
    issue_req(mk_req(OPC_MOV, 1'b0, 1, 0, 0, 0, 32'hffff_ffff));
    issue_req(mk_req(OPC_MOV, 1'b1, 2, 0, 0, 0, 32'h7fff_ffff));
    issue_req(mk_req(OPC_MOV, 1'b0, 3, 0, 0, 0, 32'h8000_0000));
    issue_req(mk_req(OPC_MOV, 1'b0, 4, 0, 0, 0, 32'h0000_0001));
    issue_req(mk_req(OPC_ADD, 1'b1, 5, 2, 4, 0, '0));
    issue_req(mk_req(OPC_ADD, 1'b1, 6, 1, 4, 0, '0));
    issue_req(mk_req(OPC_ADD, 1'b0, 7, 1, 1, 0, '0));
    issue_req(mk_req(OPC_SUB, 1'b1, 5, 3, 4, 0, '0));
    issue_req(mk_req(OPC_SUB, 1'b1, 6, 0, 4, 0, '0));
    issue_req(mk_req(OPC_SUB, 1'b0, 7, 4, 4, 0, '0));
    issue_req(mk_req(OPC_AND, 1'b1, 7, 1, 3, 0, '0));
    issue_req(mk_req(OPC_ORR, 1'b1, 7, 0, 0, 0, '0));
    issue_req(mk_req(OPC_XOR, 1'b1, 7, 1, 1, 0, '0));
    issue_req(mk_req(OPC_NOT, 1'b1, 7, 0, 0, 0, '0));
    issue_req(mk_req(OPC_NOT, 1'b0, 6, 1, 0, 0, '0));
    issue_req(mk_req(OPC_ASR, 1'b1, 5, 3, 0, 31, '0));
    issue_req(mk_req(OPC_ASR, 1'b0, 5, 2, 0, 0, '0));
    issue_req(mk_req(OPC_LSR, 1'b1, 5, 1, 0, 31, '0));
    issue_req(mk_req(OPC_LSL, 1'b1, 5, 1, 0, 31, '0));
    issue_req(mk_req(OPC_LSL, 1'b0, 6, 2, 0, 0, '0));
    issue_req(mk_req(OPC_CMP, 1'b0, 2, 3, 0, 0, '0));
    issue_req(mk_req(OPC_TST, 1'b0, 0, 1, 0, 0, '0));
    issue_req(mk_req(OPC_UNUSED_BASE, 1'b1, 1, 2, 3, 7, 32'hdead_beef));
    issue_req(mk_req(OPC_UNUSED_BASE + 4'd3, 1'b1, 7, 7, 7, 31, '1));
    wait_drained();
  endtask

  task automatic test_random(input int n_reqs, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n_reqs)
      issue_req(rand_req());
    wait_drained();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    out_stall_pct = 0;
    hold_tog <= ~hold_tog;
    repeat (40)
      issue_req(rand_req());
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++)
      arch_regs[i] = '0;
    arch_flags = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200, 0, 0);
    test_random(200, 73, 0);
    test_random(200, 0, 73);
    test_random(200, 14, 14);
    test_output_hold();
    repeat (10) @(posedge clk);

    $display("covered all opcodes with and without S, unused opcodes, shift and value extremes");
    $display("%0d requests sent, %0d results checked across idle, stall and hold phases",
             n_sent, n_checked);
    if (n_errors == 0 && pending_results.size() == 0)
      $display("tb_register_alu_with_flags OK");
    else
      $display("tb_register_alu_with_flags NOT OK");
    $finish;
  end

endmodule
